>>> sv/sarth_pkg.sv
`default_nettype none
package sarth_pkg;

  // Converter result width and the phase plan derived from it.
  localparam int SAMPLE_BITS    = 8;
  localparam int BIT_IDX_W      = $clog2(SAMPLE_BITS);
  localparam int PHASE_W        = 6;
  localparam int TICK_W         = 8;
  localparam int CFG_W          = 8;
  localparam int CFG_INDEX_W    = 8;
  localparam int IN_DATA_W      = 8;
  localparam int OUT_DATA_W     = 16;

  localparam int CMD_PHASES     = 7;
  localparam int CHAN_PHASE_LO  = 4;
  localparam int CHAN_PHASE_HI  = 5;
  localparam int MSB_FIRST_READ = 8;
  localparam int MSB_LAST_READ  = 6 + 2 * SAMPLE_BITS;
  localparam int LSB_LAST_READ  = 4 + 4 * SAMPLE_BITS;
  localparam int LAST_PHASE     = 6 + 4 * SAMPLE_BITS;

  // Configuration register indexes and reset values.
  localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_THRESHOLD = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_TICKS     = CFG_INDEX_W'(1);
  localparam logic [CFG_W-1:0]       THRESHOLD_RESET     = CFG_W'(120);
  localparam logic [CFG_W-1:0]       PHASE_TICKS_RESET   = CFG_W'(2);

  typedef struct packed {
    logic data_pin_in;
    logic channel_select;
    logic start_request;
  } item_t;

  typedef struct packed {
    logic [CFG_W-1:0] light_threshold;
    logic [CFG_W-1:0] phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic                   light_on;
    logic                   reads_agree;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic                   conversion_done;
    logic                   data_pin_drive;
    logic                   data_pin_out;
    logic                   serial_clock;
    logic                   chip_select_n;
  } result_t;

endpackage
`default_nettype wire

>>> sv/serial_adc_reader_threshold.sv
`default_nettype none
// Serial converter master with a light threshold. Each input word is one base
// tick of the sequencer that drives a two-channel 8-bit serial converter:
// on a start request while idle it runs 39 phases of phase_ticks ticks each
// (chip select low, start/single-ended/channel bits, 8 bits read on serial clock
// pulses MSB-first, 8 more read LSB-first with bit 0 shared), then raises chip select
// and publishes the sample, zero if the two reads disagree, with light_on set
// when the sample exceeds light_threshold. Every input word yields exactly one
// output word carrying the pin levels for that tick and the held result.
// One word is taken per clock cycle while the output side keeps draining; a
// word passes an input register and the sequencer logic into an output
// register, which holds it until the output side takes it. The phase and
// tick counters update once per accepted word, so every word advances the
// sequencer by one base tick and no more. Configuration writes (index
// 0 threshold, index 1 phase_ticks, other indexes ignored) are expected only
// while no conversion is under way and no word is in flight.
module serial_adc_reader_threshold (
  input  wire                                 clk,
  input  wire                                 rst,
  // tdata: [0] start_request, [1] channel_select, [2] data_pin_in, [7:3] zero
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire  [sarth_pkg::IN_DATA_W-1:0]     s_tdata,
  // tdata: [0] chip_select_n, [1] serial_clock, [2] data_pin_out,
  // [3] data_pin_drive, [4] conversion_done, [12:5] sample_value,
  // [13] reads_agree, [14] light_on, [15] zero
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [sarth_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  wire                                 cfg_we,
  input  wire  [sarth_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire  [sarth_pkg::CFG_W-1:0]         cfg_data
);
  import sarth_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid;
  logic    advance;
  result_t result;
  result_t result_q;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.light_threshold <= THRESHOLD_RESET;
      cfg.phase_ticks     <= PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIGHT_THRESHOLD: cfg.light_threshold <= cfg_data;
        REG_PHASE_TICKS:     cfg.phase_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The held word moves into the output register whenever that register is
  // empty or being drained, so the pipeline keeps one word per cycle.
  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_q.start_request  <= s_tdata[0];
      item_q.channel_select <= s_tdata[1];
      item_q.data_pin_in    <= s_tdata[2];
    end
  end

  sarth_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item_q),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign m_tdata = {1'b0, result_q};

  // A finished conversion is always reported with chip select still low.
  a_done_in_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> !m_tdata[0])
    else $error("conversion_done outside an active frame");

  // A disagreeing pair of reads must publish a zero sample and no light.
  a_disagree_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[13] |-> (m_tdata[12:5] == '0) && !m_tdata[14])
    else $error("nonzero sample published after disagreeing reads");

  // With the output register empty the input side must never stall.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while the output register is empty");

  // While released for reading, the data pin level is held at zero.
  a_release_low: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[3] |-> !m_tdata[2] && !m_tdata[0])
    else $error("data pin driven high while released");

endmodule
`default_nettype wire

>>> sv/sarth_seq.sv
`default_nettype none
module sarth_seq (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    step,
  input  sarth_pkg::item_t       item,
  input  sarth_pkg::cfg_t        cfg,
  output sarth_pkg::result_t     result
);
  import sarth_pkg::*;

  logic [PHASE_W-1:0]     phase_index, phase_index_next;
  logic [TICK_W-1:0]      tick_count, tick_count_next;
  logic                   busy_flag, busy_flag_next;
  logic                   latched_channel, latched_channel_next;
  logic [SAMPLE_BITS-1:0] msb_shift, msb_shift_next;
  logic [SAMPLE_BITS-1:0] lsb_shift, lsb_shift_next;
  logic [SAMPLE_BITS-1:0] held_sample, held_sample_next;
  logic                   held_agree, held_agree_next;
  logic                   held_light, held_light_next;

  always_comb begin
    logic [PHASE_W-1:0]     p;
    logic [PHASE_W-1:0]     bit_off;
    logic [BIT_IDX_W-1:0]   lsb_idx;
    logic [TICK_W-1:0]      len;
    logic [TICK_W-1:0]      tick_inc;
    logic [SAMPLE_BITS-1:0] msb_base;
    logic [SAMPLE_BITS-1:0] lsb_base;
    logic                   chan;
    logic                   active;
    logic                   last_tick;
    logic                   cmd_phase;

    // A start while idle makes this tick the first tick of phase zero.
    active   = busy_flag | item.start_request;
    p        = busy_flag ? phase_index : '0;
    chan     = busy_flag ? latched_channel : item.channel_select;
    msb_base = busy_flag ? msb_shift : '0;
    lsb_base = busy_flag ? lsb_shift : '0;
    tick_inc = (busy_flag ? tick_count : '0) + TICK_W'(1);
    len      = (cfg.phase_ticks == '0) ? TICK_W'(1) : cfg.phase_ticks;
    last_tick = (tick_inc >= len);
    cmd_phase = (p < PHASE_W'(CMD_PHASES));
    bit_off  = p - PHASE_W'(MSB_LAST_READ);
    lsb_idx  = bit_off[BIT_IDX_W:1];

    phase_index_next     = phase_index;
    tick_count_next      = tick_count;
    busy_flag_next       = busy_flag;
    latched_channel_next = item.start_request && !busy_flag ? item.channel_select
                                                             : latched_channel;
    msb_shift_next       = msb_shift;
    lsb_shift_next       = lsb_shift;
    held_sample_next     = held_sample;
    held_agree_next      = held_agree;
    held_light_next      = held_light;

    result.chip_select_n   = !active;
    result.serial_clock    = active & p[0];
    result.data_pin_drive  = !active | cmd_phase;
    result.conversion_done = 1'b0;
    if (!active) begin
      result.data_pin_out = 1'b1;
    end else if (cmd_phase) begin
      result.data_pin_out = (p == PHASE_W'(CHAN_PHASE_LO) || p == PHASE_W'(CHAN_PHASE_HI))
                            ? chan : 1'b1;
    end else begin
      result.data_pin_out = 1'b0;
    end

    if (active) begin
      busy_flag_next  = 1'b1;
      phase_index_next = p;
      tick_count_next = tick_inc;
      msb_shift_next  = msb_base;
      lsb_shift_next  = lsb_base;
      if (last_tick) begin
        // Reads land on the last tick of each clock-low (even) phase.
        if (!p[0] && p >= PHASE_W'(MSB_FIRST_READ) && p <= PHASE_W'(MSB_LAST_READ)) begin
          msb_shift_next = {msb_base[SAMPLE_BITS-2:0], item.data_pin_in};
        end
        if (!p[0] && p >= PHASE_W'(MSB_LAST_READ) && p <= PHASE_W'(LSB_LAST_READ)) begin
          lsb_shift_next = lsb_base | (SAMPLE_BITS'(item.data_pin_in) << lsb_idx);
        end
        tick_count_next = '0;
        if (p >= PHASE_W'(LAST_PHASE)) begin
          busy_flag_next         = 1'b0;
          phase_index_next       = '0;
          result.conversion_done = 1'b1;
          held_agree_next        = (msb_shift_next == lsb_shift_next);
          held_sample_next       = held_agree_next ? msb_shift_next : '0;
          held_light_next        = (held_sample_next > cfg.light_threshold);
        end else begin
          phase_index_next = p + PHASE_W'(1);
        end
      end
    end

    result.sample_value = held_sample_next;
    result.reads_agree  = held_agree_next;
    result.light_on     = held_light_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index     <= '0;
      tick_count      <= '0;
      busy_flag       <= 1'b0;
      latched_channel <= 1'b0;
      msb_shift       <= '0;
      lsb_shift       <= '0;
      held_sample     <= '0;
      held_agree      <= 1'b0;
      held_light      <= 1'b0;
    end else if (step) begin
      phase_index     <= phase_index_next;
      tick_count      <= tick_count_next;
      busy_flag       <= busy_flag_next;
      latched_channel <= latched_channel_next;
      msb_shift       <= msb_shift_next;
      lsb_shift       <= lsb_shift_next;
      held_sample     <= held_sample_next;
      held_agree      <= held_agree_next;
      held_light      <= held_light_next;
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_serial_adc_reader_threshold.sv
`timescale 1ns / 100ps

module tb_serial_adc_reader_threshold;
  import sarth_pkg::*;

  // An index past the two registers; the block must ignore writes to it.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = CFG_INDEX_W'(2);

  // Length of the one long receiver hold-off, in clock cycles.
  localparam int LONG_HOLD_CYCLES = 300;

  // Random ticks to send before the closing phase, and the least number of
  // finished conversions the random part should see.
  localparam int RANDOM_TICKS    = 650;
  localparam int RANDOM_CONVS    = 8;

  // How the converter's data pin is modeled while a conversion runs.
  // A clean pin returns the target sample on every read tick. Spoiling the
  // LSB-first reads makes the two reads disagree for sure; spoiling some
  // reads flips the odd read at random; noise ignores the target entirely.
  typedef enum {
    DIN_CLEAN,
    DIN_SPOIL_LSB,
    DIN_SPOIL_SOME,
    DIN_NOISE
  } pin_mode_t;

  // Scoreboard: a cycle-exact copy of the sequencer that turns each accepted
  // tick into the output word it must produce, plus the queue of those words.
  class conv_scoreboard;
    logic [CFG_W-1:0]       threshold;
    logic [CFG_W-1:0]       ticks_per_phase;
    logic [PHASE_W-1:0]     phase;
    logic [TICK_W-1:0]      tick;
    bit                     busy;
    bit                     chan_held;
    logic [SAMPLE_BITS-1:0] msb_bits;
    logic [SAMPLE_BITS-1:0] lsb_bits;
    logic [SAMPLE_BITS-1:0] sample;
    bit                     agree;
    bit                     light;
    result_t                expected_q[$];
    int                     errors;
    int                     words_checked;
    int                     conversions;

    function new();
      threshold       = THRESHOLD_RESET;
      ticks_per_phase = PHASE_TICKS_RESET;
      phase           = '0;
      tick            = '0;
      busy            = 1'b0;
      chan_held       = 1'b0;
      msb_bits        = '0;
      lsb_bits        = '0;
      sample          = '0;
      agree           = 1'b0;
      light           = 1'b0;
      errors          = 0;
      words_checked   = 0;
      conversions     = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_LIGHT_THRESHOLD) begin
        threshold = value;
      end else if (idx == REG_PHASE_TICKS) begin
        ticks_per_phase = value;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Level the converter would put on the data pin for the next tick. Only
    // the last tick of an even read phase is sampled, so everything else is
    // random. The MSB-first reads run from bit 7 down to bit 0 and the
    // LSB-first reads from bit 0 up, sharing the bit 0 tick.
    function bit pin_level(logic [SAMPLE_BITS-1:0] target, pin_mode_t mode);
      int  p;
      int  len;
      int  idx;
      bit  level;
      p   = phase;
      len = (ticks_per_phase == 0) ? 1 : ticks_per_phase;
      if (mode == DIN_NOISE || !busy || int'(tick) + 1 < len || p[0] ||
          p < MSB_FIRST_READ || p > LSB_LAST_READ) begin
        return bit'($urandom_range(0, 1));
      end
      idx   = (p <= MSB_LAST_READ) ? (MSB_LAST_READ - p) / 2 : (p - MSB_LAST_READ) / 2;
      level = target[idx];
      if (mode == DIN_SPOIL_LSB && p > MSB_LAST_READ) begin
        level = !level;
      end
      if (mode == DIN_SPOIL_SOME && $urandom_range(0, 9) == 0) begin
        level = !level;
      end
      return level;
    endfunction

    // One accepted tick: advance the sequencer and queue the word it yields.
    function void note(item_t it);
      result_t          r;
      logic [CFG_W-1:0] len;
      r                = '0;
      r.chip_select_n  = 1'b1;
      r.data_pin_out   = 1'b1;
      r.data_pin_drive = 1'b1;

      // A start while idle opens the first phase on this very tick.
      if (!busy && it.start_request) begin
        busy      = 1'b1;
        phase     = '0;
        tick      = '0;
        chan_held = it.channel_select;
        msb_bits  = '0;
        lsb_bits  = '0;
      end

      if (busy) begin
        r.chip_select_n = 1'b0;
        r.serial_clock  = phase[0];
        if (phase < CMD_PHASES) begin
          r.data_pin_out   = (phase == CHAN_PHASE_LO || phase == CHAN_PHASE_HI) ?
                             chan_held : 1'b1;
          r.data_pin_drive = 1'b1;
        end else begin
          r.data_pin_out   = 1'b0;
          r.data_pin_drive = 1'b0;
        end

        len  = (ticks_per_phase == 0) ? CFG_W'(1) : ticks_per_phase;
        tick = tick + 1'b1;
        if (tick >= len) begin
          if (!phase[0] && phase >= MSB_FIRST_READ && phase <= MSB_LAST_READ) begin
            msb_bits = {msb_bits[SAMPLE_BITS-2:0], it.data_pin_in};
          end
          if (!phase[0] && phase >= MSB_LAST_READ && phase <= LSB_LAST_READ) begin
            lsb_bits[(phase - MSB_LAST_READ) >> 1] = it.data_pin_in;
          end
          tick = '0;
          if (phase >= LAST_PHASE) begin
            busy              = 1'b0;
            phase             = '0;
            r.conversion_done = 1'b1;
            agree             = (msb_bits == lsb_bits);
            sample            = agree ? msb_bits : '0;
            light             = (sample > threshold);
            conversions++;
          end else begin
            phase = phase + 1'b1;
          end
        end
      end

      r.sample_value = sample;
      r.reads_agree  = agree;
      r.light_on     = light;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check(result_t got);
      result_t want;
      words_checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $error("output word %h arrived with no expectation waiting", got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("chip_select_n", want.chip_select_n, got.chip_select_n);
      compare_field("serial_clock", want.serial_clock, got.serial_clock);
      compare_field("data_pin_out", want.data_pin_out, got.data_pin_out);
      compare_field("data_pin_drive", want.data_pin_drive, got.data_pin_drive);
      compare_field("conversion_done", want.conversion_done, got.conversion_done);
      compare_field("sample_value", want.sample_value, got.sample_value);
      compare_field("reads_agree", want.reads_agree, got.reads_agree);
      compare_field("light_on", want.light_on, got.light_on);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  conv_scoreboard sb = new();

  // steady switches off all random idling for the closing phase; hold_armed
  // lets the receiver run its one long hold-off once random traffic flows.
  bit steady     = 1'b0;
  bit hold_armed = 1'b0;
  int ticks_sent = 0;

  serial_adc_reader_threshold uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Every output word accepted by the receiver is checked at the edge where
  // the handshake completes.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check(result_t'(m_tdata[$bits(result_t)-1:0]));
    end
  end

  // Receiver: ready most of the time, with random stall bursts. Once armed it
  // holds off for one long stretch so that the block's buffering fills up and
  // s_tready drops while the sender keeps offering words.
  initial begin : receiver
    int  stall;
    bit  held_long;
    held_long = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !held_long) begin
        held_long = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
      end else if (!steady && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 13);
        m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offers one tick and returns at the edge where it is taken. The predictor
  // is advanced right there, so the next tick can be shaped from its state.
  task automatic send_tick(bit start, bit chan, bit din);
    item_t it;
    int    gap;
    it.start_request  = start;
    it.channel_select = chan;
    it.data_pin_in    = din;
    if (!steady && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - $bits(item_t)){1'b0}}, it};
    do @(posedge clk); while (!s_tready);
    sb.note(it);
    ticks_sent++;
  endtask

  // Runs one conversion from its start tick to its done tick. With
  // poke_start set, start requests keep arriving at random while busy.
  task automatic run_conversion(bit chan, logic [SAMPLE_BITS-1:0] target,
                                pin_mode_t mode, bit poke_start);
    send_tick(1'b1, chan, sb.pin_level(target, mode));
    while (sb.busy) begin
      send_tick(poke_start ? bit'($urandom_range(0, 1)) : 1'b0,
                bit'($urandom_range(0, 1)), sb.pin_level(target, mode));
    end
  endtask

  task automatic idle_ticks(int count);
    repeat (count) begin
      send_tick(1'b0, bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
    end
  endtask

  // Brings the block to rest: finishes any conversion, stops sending, waits
  // for every expected word and then for the pipeline to go quiet.
  task automatic settle();
    while (sb.busy) begin
      send_tick(1'b0, bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] ticks);
    settle();
    write_reg(REG_LIGHT_THRESHOLD, thr);
    write_reg(REG_PHASE_TICKS, ticks);
  endtask

  initial begin : stimulus
    int                     quota;
    int                     conv_base;
    int                     tick_base;
    int                     pick;
    logic [CFG_W-1:0]       thr;
    logic [CFG_W-1:0]       ticks;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. First the reset settings: threshold 120, two ticks per
    // phase. A sample one above the threshold lights, one equal does not.
    idle_ticks(3);
    run_conversion(1'b0, 8'd121, DIN_CLEAN, 1'b0);
    run_conversion(1'b1, 8'd120, DIN_CLEAN, 1'b1);

    // Shortest phases and the lowest threshold: an all-zero sample on channel 0
    // and an all-one sample on channel 1, then reads that disagree and so yield zero.
    configure(8'd0, 8'd1);
    run_conversion(1'b0, 8'h00, DIN_CLEAN, 1'b1);
    run_conversion(1'b1, 8'hFF, DIN_CLEAN, 1'b0);
    run_conversion(1'b1, 8'hA5, DIN_SPOIL_LSB, 1'b0);
    idle_ticks(4);

    // A phase length of zero must behave as one; the top threshold keeps the
    // light off even for a full-scale sample.
    configure(8'd255, 8'd0);
    run_conversion(1'b1, 8'hFF, DIN_CLEAN, 1'b0);
    run_conversion(1'b0, 8'h5A, DIN_CLEAN, 1'b1);

    // A write past the last register changes nothing.
    settle();
    write_reg(REG_UNMAPPED, 8'd3);
    run_conversion(1'b1, 8'h81, DIN_CLEAN, 1'b0);

    // Lowering the threshold alone leaves the held light as it was; only the
    // next completed conversion reevaluates it.
    settle();
    write_reg(REG_LIGHT_THRESHOLD, 8'd0);
    idle_ticks(5);
    run_conversion(1'b0, 8'h01, DIN_CLEAN, 1'b0);

    // Longer phases once, with a sample equal to the threshold.
    configure(8'd128, 8'd6);
    run_conversion(1'b1, 8'h80, DIN_CLEAN, 1'b1);

    // Random part: a new setting every 150 or so ticks; mostly well-formed
    // conversions with random samples, the rest random ticks, noise and spoiled reads.
    conv_base  = sb.conversions;
    tick_base  = ticks_sent;
    while (ticks_sent - tick_base < RANDOM_TICKS ||
           sb.conversions - conv_base < RANDOM_CONVS) begin
      pick = $urandom_range(0, 9);
      thr  = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : CFG_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      ticks = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd2 : (pick == 2) ? 8'd3 : 8'd1;
      configure(thr, ticks);
      // The long hold-off starts while the sender is busy offering ticks.
      hold_armed = 1'b1;
      quota = ticks_sent + 150;
      while (ticks_sent < quota) begin
        case ($urandom_range(0, 9))
          0: begin
            repeat ($urandom_range(1, 12)) begin
              send_tick($urandom_range(0, 3) == 0, bit'($urandom_range(0, 1)),
                        bit'($urandom_range(0, 1)));
            end
          end
          1: run_conversion(bit'($urandom_range(0, 1)), SAMPLE_BITS'($urandom_range(0, 255)),
                            DIN_SPOIL_SOME, bit'($urandom_range(0, 1)));
          2: run_conversion(bit'($urandom_range(0, 1)), SAMPLE_BITS'($urandom_range(0, 255)),
                            DIN_NOISE, bit'($urandom_range(0, 1)));
          default: begin
            run_conversion(bit'($urandom_range(0, 1)), SAMPLE_BITS'($urandom_range(0, 255)),
                           DIN_CLEAN, bit'($urandom_range(0, 1)));
            idle_ticks($urandom_range(0, 5));
          end
        endcase
      end
    end

    // Closing phase at full rate on both sides.
    configure(CFG_W'($urandom_range(0, 255)), 8'd1);
    steady = 1'b1;
    repeat (4) begin
      run_conversion(bit'($urandom_range(0, 1)), SAMPLE_BITS'($urandom_range(0, 255)),
                     DIN_CLEAN, 1'b0);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d ticks and checked %0d output words; %0d conversions finished.",
             ticks_sent, sb.words_checked, sb.conversions);
    $display("Phase lengths 0 to 6, thresholds 0 to 255, disagreeing reads and starts while busy were covered.");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, including the long receiver
  // hold-off and random stalls on both sides.
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
sv/sarth_pkg.sv
sv/sarth_seq.sv
sv/serial_adc_reader_threshold.sv
tb/tb_serial_adc_reader_threshold.sv
